### rtl/double_ended_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Plain property check
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define DEQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Opcodes, status codes, controller states and shared widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DEQ_DEPTH_DEF     = 16;
  localparam int DEQ_WORD_BITS_DEF = 32;

  // Request and result field widths
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // take the request and update pointers
    logic load_read;  // capture the ring read data into the result
  } deq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_read; // request at the input reads the ring
  } deq_sts_t;

endpackage

`default_nettype wire

### rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Request handshake, ring read wait state and result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_unit_macros.svh"

module deq_ctrl
  import deq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  input  wire deq_sts_t sts,
  output deq_cmd_t      cmd
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    // Take a request only when the result slot is free or drains this cycle
    s_tready       = (state == S_IDLE) && (!out_valid || m_tready);
    accept         = s_tvalid && s_tready;
    cmd.accept     = accept;
    cmd.load_read  = 1'b0;

    if (m_tready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.needs_read) begin
            state_next = S_EXEC;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      S_EXEC: begin
        cmd.load_read  = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;

  `DEQ_ASSERT_NEXT(a_read_waits, accept && sts.needs_read, !m_tvalid, "result shown before ring data")
  `DEQ_ASSERT_NEXT(a_read_shown, cmd.load_read, m_tvalid, "ring read gave no result")
  `DEQ_ASSERT_IMPL(a_no_overrun, out_valid && !m_tready, !s_tready, "request taken over held result")

endmodule

`default_nettype wire

### rtl/deq_dp.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring pointers, occupancy, ring RAM and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_unit_macros.svh"

module deq_dp
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEQ_DEPTH_DEF,
  parameter int WORD_BITS = DEQ_WORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire deq_cmd_t           cmd,
  input  wire logic [OPCODE_W-1:0] opcode,
  input  wire logic [VALUE_W-1:0] push_value,
  output deq_sts_t                sts,
  output logic [VALUE_W-1:0]      read_value,
  output logic [STATUS_W-1:0]     status,
  output logic [OCC_W-1:0]        occupancy,
  output logic                    is_empty
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0]     LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]     FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

  logic [IDX_W-1:0] head, head_next, tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             full, empty;
  opcode_t          op;

  logic                 ram_en, ram_we;
  logic [IDX_W-1:0]     ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  status_t          res_status;
  logic [VALUE_W-1:0] res_const;
  logic             needs_read;

  assign op    = opcode_t'(opcode);
  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);

  // Ring wrap
  assign head_inc = (head == LAST_SLOT) ? '0 : head + IDX_W'(1);
  assign head_dec = (head == '0) ? LAST_SLOT : head - IDX_W'(1);
  assign tail_inc = (tail == LAST_SLOT) ? '0 : tail + IDX_W'(1);
  assign tail_dec = (tail == '0) ? LAST_SLOT : tail - IDX_W'(1);

  assign ram_wdata = WORD_BITS'($unsigned(push_value));

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = head;
    res_status = STS_OK;
    res_const  = '0;
    needs_read = 1'b0;

    unique case (op) inside
      OP_PUSH_FRONT: begin
        if (full) begin
          res_status = STS_FULL;
        end else begin
          ram_en     = 1'b1;
          ram_we     = 1'b1;
          ram_addr   = head_dec;
          head_next  = head_dec;
          count_next = count + CNT_W'(1);
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          res_status = STS_FULL;
        end else begin
          ram_en     = 1'b1;
          ram_we     = 1'b1;
          ram_addr   = tail;
          tail_next  = tail_inc;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          res_status = STS_EMPTY;
          res_const  = VALUE_W'(WORD_ONES);
        end else begin
          ram_en     = 1'b1;
          ram_addr   = head;
          needs_read = 1'b1;
          if (op == OP_POP_FRONT) begin
            head_next  = head_inc;
            count_next = count - CNT_W'(1);
          end
        end
      end
      OP_POP_REAR, OP_PEEK_REAR: begin
        if (empty) begin
          res_status = STS_EMPTY;
          res_const  = VALUE_W'(WORD_ONES);
        end else begin
          ram_en     = 1'b1;
          ram_addr   = tail_dec;
          needs_read = 1'b1;
          if (op == OP_POP_REAR) begin
            tail_next  = tail_dec;
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.needs_read = needs_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Result registers: everything but read data is known at accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      read_value <= res_const;
      status     <= res_status;
      occupancy  <= OCC_W'(count_next);
      is_empty   <= (count_next == '0);
    end else if (cmd.load_read) begin
      read_value <= VALUE_W'(ram_rdata);
    end
  end

  deq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en && cmd.accept),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  `DEQ_ASSERT(a_count_bound, count <= FULL_CNT, "occupancy beyond ring depth")
  `DEQ_ASSERT_IMPL(a_ptr_meet, empty || full, head == tail, "pointers apart when empty or full")

endmodule

`default_nettype wire

### rtl/double_ended_queue_unit.sv
// Result path: a push result is registered on the edge that takes the request; a
//   pop or peek result passes the registered ring read, then the result register.
// Throughput: one request per cycle for pushes and for reads of an empty queue,
//   while m_tready drains the result; for pops and peeks of a filled queue the
//   controller holds off the next request while it waits in S_EXEC for the read.
// Reset: rst clears head, tail, occupancy and the result valid; ring contents are
//   left as they are and are only read once written.
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Ring-buffer deque of unsigned words with push, pop and peek at either end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEQ_DEPTH_DEF,     // ring entries, 2 to 31
  parameter int WORD_BITS = DEQ_WORD_BITS_DEF  // stored word width, 1 to 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Request stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // opcode[2:0], push_value[34:3], zero pad
  // Result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata   // read_value[31:0], status[33:32],
                                               // occupancy[38:34], is_empty[39]
);

  deq_cmd_t            cmd;
  deq_sts_t            sts;
  logic [VALUE_W-1:0]  read_value;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;
  logic                is_empty;

  // Controller: owns the handshake and steps through the ring read wait
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: decode the request straight off the bus; pointers advance and
  // pushes are written on the accepting edge, reads reach the result from S_EXEC
  deq_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .opcode     (s_tdata[OPCODE_W-1:0]),
    .push_value (s_tdata[OPCODE_W+VALUE_W-1:OPCODE_W]),
    .sts        (sts),
    .read_value (read_value),
    .status     (status),
    .occupancy  (occupancy),
    .is_empty   (is_empty)
  );

  // Pack the result, lowest field first
  assign m_tdata = {is_empty, occupancy, status, read_value};

endmodule

`default_nettype wire
